[rtl/wtm_pkg.sv]
package wtm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] REQ_CHECK  = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [2:0] KIND_CPU_WRITE     = 3'd0;
  localparam logic [2:0] KIND_PALETTE_WRITE = 3'd1;

  localparam logic [31:0] CPU_ADDR_MASK = 32'h00FF_FFFF;
  localparam logic [8:0]  PAL_B_MASK    = 9'h1C0;
  localparam logic [8:0]  PAL_G_MASK    = 9'h038;
  localparam logic [8:0]  PAL_R_MASK    = 9'h007;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  span;
    logic [7:0]  kinds;
    logic [31:0] cond_value;
    logic        cond;
    logic        once;
  } entry_t;

  // request as seen by every cell
  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [7:0]  width;
    logic [31:0] value;
    logic [15:0] pal_value;
  } probe_t;

  // priority chain carried from cell to cell
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] slot;
    logic             once;
  } chain_t;

  typedef struct packed {
    logic load;
    logic remove;
  } cell_cmd_t;

  // BBBGGGRRR -> BBB0GGG0RRR0
  function automatic logic [15:0] palette_expand(input logic [8:0] v);
    logic [15:0] r;
    r = ({7'd0, v & PAL_B_MASK} << 3) | ({7'd0, v & PAL_G_MASK} << 2)
      | ({7'd0, v & PAL_R_MASK} << 1);
    return r;
  endfunction

endpackage

[rtl/watchpoint_table_matcher.sv]
// Watchpoint table matcher.
// Input channel (in_valid/in_ready) carries one request per transaction:
// check a bus access, add an entry, delete the first entry at an address,
// or clear the table. Result channel (out_valid/out_ready) returns exactly
// one transaction per request: hit, hit_slot, status and entry_count.
// The table is a row of cells, one entry each, held in insertion order.
// Every cell compares the request against its entry at once; a found flag
// runs down the row so the lowest matching position wins, and a removal
// shifts every later entry down one cell in the same cycle.
// Result path: the request is registered on acceptance, then the per-cell
// compare register, then priority pick, table update and output register.
// The row works on one request at a time. in_ready is high in the idle
// state even while a result waits.
// Stall: if out_ready is low, the finished result holds in the output
// register and the next request waits after its compare cycle.
// Reset: entry count goes to zero, no result pending; entry storage is not
// cleared and is only read below the entry count.
module watchpoint_table_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [2:0]  in_access_kind,
  input  logic [31:0] in_address,
  input  logic [7:0]  in_width,
  input  logic [31:0] in_value,
  input  logic [7:0]  in_kind_mask,
  input  logic        in_has_condition,
  input  logic [31:0] in_match_value,
  input  logic        in_once_only,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [3:0]  out_hit_slot,
  output logic [1:0]  out_status,
  output logic [4:0]  out_entry_count
);

  localparam int DEPTH = wtm_pkg::TABLE_DEPTH;
  localparam int CW    = wtm_pkg::CNT_W;
  localparam int IW    = wtm_pkg::IDX_W;

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_APPLY} state_t;

  state_t            state_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic              out_valid_r;
  logic              out_hit_r;
  logic [3:0]        out_slot_r;
  logic [1:0]        out_status_r;
  logic [4:0]        out_count_r;

  // captured request
  logic [1:0]        req_type_r;
  logic [2:0]        kind_r;
  logic [31:0]       addr_r;
  logic [7:0]        width_r;
  logic [31:0]       value_r;
  logic [7:0]        kmask_r;
  logic              cond_r;
  logic [31:0]       mval_r;
  logic              once_r;

  wtm_pkg::probe_t   probe;
  wtm_pkg::entry_t   new_entry;
  wtm_pkg::entry_t   entries   [DEPTH];
  wtm_pkg::chain_t   chain     [DEPTH+1];
  wtm_pkg::cell_cmd_t cmds     [DEPTH];
  logic [DEPTH-1:0]  load_vec;

  logic              in_fire;
  logic              apply_fire;
  logic              found;
  logic              add_ok;
  logic              remove_en;
  logic              res_hit;
  logic [1:0]        res_status;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign apply_fire = (state_r == ST_APPLY) && (!out_valid_r || out_ready);

  // request-side preprocessing shared by all cells
  always_comb begin
    probe.req_type  = req_type_r;
    probe.kind      = kind_r;
    probe.width     = width_r;
    probe.value     = value_r;
    probe.pal_value = wtm_pkg::palette_expand(value_r[8:0]);
    if (req_type_r == wtm_pkg::REQ_CHECK && kind_r == wtm_pkg::KIND_CPU_WRITE) begin
      probe.addr = addr_r & wtm_pkg::CPU_ADDR_MASK;
    end else begin
      probe.addr = addr_r;
    end
    new_entry.addr       = addr_r;
    new_entry.span       = width_r;
    new_entry.kinds      = kmask_r;
    new_entry.cond_value = mval_r;
    new_entry.cond       = cond_r;
    new_entry.once       = once_r;
  end

  assign chain[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      wtm_pkg::entry_t nbr;
      if (gi == DEPTH - 1) begin : g_last
        assign nbr = entries[gi];
      end else begin : g_mid
        assign nbr = entries[gi+1];
      end
      assign load_vec[gi]    = apply_fire && add_ok && (cnt_r == CW'(gi));
      assign cmds[gi].load   = load_vec[gi];
      assign cmds[gi].remove = apply_fire && remove_en;

      wtm_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (CW'(gi) < cnt_r),
        .idx        (IW'(gi)),
        .probe      (probe),
        .cmd        (cmds[gi]),
        .new_entry  (new_entry),
        .next_entry (nbr),
        .chain_in   (chain[gi]),
        .chain_out  (chain[gi+1]),
        .entry_out  (entries[gi])
      );
    end
  endgenerate

  // outcome of the request, from the end of the priority chain
  always_comb begin
    found      = chain[DEPTH].found;
    add_ok     = (req_type_r == wtm_pkg::REQ_ADD) && (cnt_r < CW'(DEPTH));
    remove_en  = 1'b0;
    res_hit    = 1'b0;
    res_status = wtm_pkg::STATUS_OK;
    cnt_nxt    = cnt_r;
    unique case (req_type_r)
      wtm_pkg::REQ_CHECK: begin
        res_hit   = found;
        remove_en = found && chain[DEPTH].once;
        if (remove_en) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      wtm_pkg::REQ_ADD: begin
        if (add_ok) begin
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          res_status = wtm_pkg::STATUS_FULL;
        end
      end
      wtm_pkg::REQ_DELETE: begin
        remove_en = found;
        if (found) begin
          cnt_nxt = cnt_r - CW'(1);
        end else begin
          res_status = wtm_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          if (apply_fire) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (apply_fire) begin
        cnt_r        <= cnt_nxt;
        out_valid_r  <= 1'b1;
        out_hit_r    <= res_hit;
        out_slot_r   <= res_hit ? 4'(chain[DEPTH].slot) : 4'd0;
        out_status_r <= res_status;
        out_count_r  <= 5'(cnt_nxt);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r <= in_req_type;
      kind_r     <= in_access_kind;
      addr_r     <= in_address;
      width_r    <= in_width;
      value_r    <= in_value;
      kmask_r    <= in_kind_mask;
      cond_r     <= in_has_condition;
      mval_r     <= in_match_value;
      once_r     <= in_once_only;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_hit_slot    = out_slot_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !apply_fire |=> $stable(cnt_r))
    else $error("entry count changed outside table update");

  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(load_vec))
    else $error("more than one cell loaded");

  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    apply_fire && res_hit |-> res_status == wtm_pkg::STATUS_OK && found)
    else $error("hit with non-ok status");

  a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    apply_fire && res_status == wtm_pkg::STATUS_FULL |-> cnt_r == CW'(DEPTH))
    else $error("add refused while table not full");
`endif

endmodule

[rtl/wtm_cell.sv]
module wtm_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid,
  input  logic [wtm_pkg::IDX_W-1:0]   idx,
  input  wtm_pkg::probe_t             probe,
  input  wtm_pkg::cell_cmd_t          cmd,
  input  wtm_pkg::entry_t             new_entry,
  input  wtm_pkg::entry_t             next_entry,
  input  wtm_pkg::chain_t             chain_in,
  output wtm_pkg::chain_t             chain_out,
  output wtm_pkg::entry_t             entry_out
);

  wtm_pkg::entry_t entry_r;
  logic            sel_r;
  logic            sel_nxt;
  logic            first;
  logic [31:0]     cmp_value;
  logic [32:0]     entry_hi;
  logic [32:0]     access_hi;
  logic            kind_ok;
  logic            cond_ok;
  logic            range_ok;

  always_comb begin
    if (probe.kind == wtm_pkg::KIND_PALETTE_WRITE) begin
      if (entry_r.span == 8'd1 && entry_r.addr[0]) begin
        cmp_value = {24'd0, probe.pal_value[7:0]};
      end else begin
        cmp_value = {16'd0, probe.pal_value};
      end
    end else begin
      cmp_value = probe.value;
    end
    kind_ok   = entry_r.kinds[probe.kind];
    cond_ok   = !entry_r.cond || (entry_r.cond_value == cmp_value);
    entry_hi  = {1'b0, entry_r.addr} + {25'd0, entry_r.span};
    access_hi = {1'b0, probe.addr} + {25'd0, probe.width};
    range_ok  = ({1'b0, probe.addr} <= entry_hi) && (access_hi >= {1'b0, entry_r.addr});
    unique case (probe.req_type)
      wtm_pkg::REQ_CHECK:  sel_nxt = valid && kind_ok && cond_ok && range_ok;
      wtm_pkg::REQ_DELETE: sel_nxt = valid && (entry_r.addr == probe.addr);
      default:             sel_nxt = 1'b0;
    endcase
  end

  // first match in the row: nothing found to the left
  assign first           = sel_r && !chain_in.found;
  assign chain_out.found = chain_in.found || sel_r;
  assign chain_out.slot  = first ? idx : chain_in.slot;
  assign chain_out.once  = first ? entry_r.once : chain_in.once;
  assign entry_out       = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  // removal pulls the neighbor down into this position and every later one
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry_r <= new_entry;
    end else if (cmd.remove && chain_out.found) begin
      entry_r <= next_entry;
    end
  end

endmodule

[tb/watchpoint_table_matcher_checker.sv]
module watchpoint_table_matcher_checker
  import wtm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [2:0]  in_access_kind,
  input  logic [31:0] in_address,
  input  logic [7:0]  in_width,
  input  logic [31:0] in_value,
  input  logic [7:0]  in_kind_mask,
  input  logic        in_has_condition,
  input  logic [31:0] in_match_value,
  input  logic        in_once_only,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_hit,
  input  logic [3:0]  out_hit_slot,
  input  logic [1:0]  out_status,
  input  logic [4:0]  out_entry_count,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
    logic [1:0] status;
    logic [4:0] count;
  } outcome_t;

  entry_t   watch_list [TABLE_DEPTH];
  int       held;
  outcome_t outcome_q [$];

  function automatic void note_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    fail_count++;
    $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
  endfunction

  function automatic void drop_entry(input int pos);
    int i;
    for (i = pos; i + 1 < held; i++)
      watch_list[i] = watch_list[i + 1];
    held--;
  endfunction

  function automatic outcome_t apply_request(
    input logic [1:0]  req,
    input logic [2:0]  kind,
    input logic [31:0] addr,
    input logic [7:0]  wid,
    input logic [31:0] val,
    input logic [7:0]  kmask,
    input logic        cond,
    input logic [31:0] mval,
    input logic        once
  );
    outcome_t    o;
    logic [32:0] acc_lo, acc_hi, ent_hi;
    logic [31:0] pal_val, cmp_val;
    int          i, pos;
    o   = '0;
    pos = -1;
    case (req)
      REQ_CHECK: begin
        acc_lo  = (kind == KIND_CPU_WRITE) ? {1'b0, addr & CPU_ADDR_MASK} : {1'b0, addr};
        acc_hi  = acc_lo + wid;
        pal_val = {20'd0, val[8:6], 1'b0, val[5:3], 1'b0, val[2:0], 1'b0};
        for (i = 0; i < held; i++) begin
          if (pos < 0 && watch_list[i].kinds[kind]) begin
            cmp_val = val;
            if (kind == KIND_PALETTE_WRITE) begin
              cmp_val = pal_val;
              if (watch_list[i].span == 8'd1 && watch_list[i].addr[0])
                cmp_val = {24'd0, pal_val[7:0]};
            end
            ent_hi = {1'b0, watch_list[i].addr} + watch_list[i].span;
            if ((!watch_list[i].cond || watch_list[i].cond_value == cmp_val) &&
                acc_lo <= ent_hi && acc_hi >= {1'b0, watch_list[i].addr})
              pos = i;
          end
        end
        if (pos >= 0) begin
          o.hit  = 1'b1;
          o.slot = 4'(pos);
          if (watch_list[pos].once)
            drop_entry(pos);
        end
      end
      REQ_ADD: begin
        if (held >= TABLE_DEPTH) begin
          o.status = STATUS_FULL;
        end else begin
          watch_list[held] = '{addr: addr, span: wid, kinds: kmask, cond_value: mval,
                               cond: cond, once: once};
          held++;
        end
      end
      REQ_DELETE: begin
        o.status = STATUS_NOT_FOUND;
        for (i = 0; i < held; i++) begin
          if (pos < 0 && watch_list[i].addr == addr)
            pos = i;
        end
        if (pos >= 0) begin
          drop_entry(pos);
          o.status = STATUS_OK;
        end
      end
      default: begin
        held = 0;
      end
    endcase
    o.count = 5'(held);
    return o;
  endfunction

  always @(posedge clk) begin : track
    outcome_t want;
    if (!rst_n) begin
      held       = 0;
      fail_count = 0;
      outcome_q.delete();
    end else begin
      // result side first: a request accepted on this edge cannot answer yet
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          fail_count++;
          $error("result transaction with no request outstanding");
        end else begin
          want = outcome_q.pop_front();
          if (out_hit !== want.hit)
            note_mismatch("hit", 32'(want.hit), 32'(out_hit));
          if (out_hit_slot !== want.slot)
            note_mismatch("hit_slot", 32'(want.slot), 32'(out_hit_slot));
          if (out_status !== want.status)
            note_mismatch("status", 32'(want.status), 32'(out_status));
          if (out_entry_count !== want.count)
            note_mismatch("entry_count", 32'(want.count), 32'(out_entry_count));
        end
      end
      if (in_valid && in_ready)
        outcome_q.push_back(apply_request(in_req_type, in_access_kind, in_address, in_width,
                                          in_value, in_kind_mask, in_has_condition,
                                          in_match_value, in_once_only));
    end
    pending = outcome_q.size();
  end

endmodule

[tb/tb_watchpoint_table_matcher.sv]
module tb_watchpoint_table_matcher;
  import wtm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Random part: blocks of requests, each block with its own traffic mix.
  // The last two blocks run with no idling on either side.
  localparam int RANDOM_BLOCKS = 14;
  localparam int BLOCK_ITEMS   = 125;
  // Extra cycles after the last result comes back, to catch strays.
  localparam int DRAIN_CYCLES  = 16;
  // The worst case per request is idle gaps on both sides plus the pass
  // through the row; for 1800 requests the watchdog allows a wide margin.
  localparam int CYCLE_LIMIT   = 400_000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [2:0]  in_access_kind;
  logic [31:0] in_address;
  logic [7:0]  in_width;
  logic [31:0] in_value;
  logic [7:0]  in_kind_mask;
  logic        in_has_condition;
  logic [31:0] in_match_value;
  logic        in_once_only;
  logic        out_valid;
  logic        out_ready;
  logic        out_hit;
  logic [3:0]  out_hit_slot;
  logic [1:0]  out_status;
  logic [4:0]  out_entry_count;

  int          mismatches;
  int          pending_results;
  int          cycles = 0;
  bit          quiet = 1'b0;   // no idling on either side while set

  // Small pools of addresses and data so that adds, deletes and checks
  // land on each other often enough to hit.
  logic [31:0] base_pool [8];
  logic [31:0] val_pool  [4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  watchpoint_table_matcher uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_access_kind  (in_access_kind),
    .in_address      (in_address),
    .in_width        (in_width),
    .in_value        (in_value),
    .in_kind_mask    (in_kind_mask),
    .in_has_condition(in_has_condition),
    .in_match_value  (in_match_value),
    .in_once_only    (in_once_only),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_hit_slot    (out_hit_slot),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  watchpoint_table_matcher_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_access_kind  (in_access_kind),
    .in_address      (in_address),
    .in_width        (in_width),
    .in_value        (in_value),
    .in_kind_mask    (in_kind_mask),
    .in_has_condition(in_has_condition),
    .in_match_value  (in_match_value),
    .in_once_only    (in_once_only),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_hit_slot    (out_hit_slot),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .fail_count      (mismatches),
    .pending         (pending_results)
  );

  // 9-bit BBBGGGRRR color to its 16-bit bus form, for building match values
  function automatic logic [15:0] palette_code(input logic [8:0] v);
    return {4'd0, v[8:6], 1'b0, v[5:3], 1'b0, v[2:0], 1'b0};
  endfunction

  // Present one request transaction. Fields change at the falling edge; an
  // optional idle burst drops valid first. Returns once the transaction has
  // been taken at a rising edge.
  task automatic push_request(
    input logic [1:0]  req,
    input logic [2:0]  kind,
    input logic [31:0] addr,
    input logic [7:0]  wid,
    input logic [31:0] val,
    input logic [7:0]  kmask,
    input logic        cond,
    input logic [31:0] mval,
    input logic        once
  );
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_req_type      = req;
    in_access_kind   = kind;
    in_address       = addr;
    in_width         = wid;
    in_value         = val;
    in_kind_mask     = kmask;
    in_has_condition = cond;
    in_match_value   = mval;
    in_once_only     = once;
    in_valid         = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // One random request. Every field starts fully random (so fields that a
  // request type ignores still toggle), then the fields that matter are
  // steered toward the address and value pools.
  task automatic random_request(input bit add_heavy);
    logic [1:0]  req;
    logic [2:0]  kind;
    logic [31:0] addr, val, mval, base, pv;
    logic [7:0]  wid, kmask;
    logic [15:0] pal;
    logic        cond, once;
    int          pick, add_top;
    req   = 2'($urandom);
    kind  = 3'($urandom);
    addr  = $urandom;
    wid   = 8'($urandom);
    val   = $urandom;
    kmask = 8'($urandom);
    cond  = 1'($urandom);
    mval  = $urandom;
    once  = 1'($urandom);
    base  = base_pool[$urandom_range(0, 7)];
    pv    = val_pool[$urandom_range(0, 3)];
    pal   = palette_code(pv[8:0]);
    pick  = $urandom_range(0, 99);
    add_top = add_heavy ? 55 : 35;
    if (pick < 8) begin
      // noise: leave everything random
    end else if (pick < 10) begin
      req = REQ_CLEAR;
    end else if (pick < add_top) begin
      req   = REQ_ADD;
      addr  = base + $urandom_range(0, 16);
      wid   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
      kmask = $urandom_range(0, 1) ? 8'(1 << $urandom_range(0, 7)) : 8'($urandom);
      cond  = ($urandom_range(0, 2) == 0);
      once  = ($urandom_range(0, 3) == 0);
      // condition value in raw, expanded or low-byte form
      case ($urandom_range(0, 3))
        0:       mval = pv;
        1:       mval = {16'd0, pal};
        2:       mval = {24'd0, pal[7:0]};
        default: mval = $urandom;
      endcase
    end else if (pick < add_top + 12) begin
      req = REQ_DELETE;
      if ($urandom_range(0, 3) != 0)
        addr = base + $urandom_range(0, 16);
    end else begin
      req = REQ_CHECK;
      // lean on the two kinds with special handling
      case ($urandom_range(0, 3))
        0:       kind = KIND_CPU_WRITE;
        1:       kind = KIND_PALETTE_WRITE;
        default: ;
      endcase
      addr = base + $urandom_range(0, 24);
      // junk in the top byte must not matter for a processor write
      if (kind == KIND_CPU_WRITE && $urandom_range(0, 1))
        addr[31:24] = 8'($urandom);
      wid = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
      val = pv;
      // only the low 9 bits feed the palette expansion
      if (kind == KIND_PALETTE_WRITE && $urandom_range(0, 1))
        val[31:9] = 23'($urandom);
    end
    push_request(req, kind, addr, wid, val, kmask, cond, mval, once);
  endtask

  // Receiver pacing: out_ready low in random-length bursts, never while quiet.
  initial begin : sink_pacing
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (quiet) begin
        hold      = 0;
        out_ready = 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        hold      = $urandom_range(0, 16);
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("** watchpoint_table_matcher: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int blk, k;
    bit heavy;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_req_type      = REQ_CHECK;
    in_access_kind   = KIND_CPU_WRITE;
    in_address       = '0;
    in_width         = '0;
    in_value         = '0;
    in_kind_mask     = '0;
    in_has_condition = 1'b0;
    in_match_value   = '0;
    in_once_only     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    base_pool[0] = {8'd0, 24'($urandom)};
    base_pool[1] = 32'h0000_0100;
    base_pool[2] = 32'h0000_0000;
    base_pool[3] = 32'hFFFF_FFF0;   // near the top: range sums need 33 bits
    for (k = 4; k < 8; k++)
      base_pool[k] = $urandom;
    val_pool[0] = $urandom;
    val_pool[1] = 32'h0000_01FF;
    val_pool[2] = {23'd0, 9'($urandom)};
    val_pool[3] = $urandom;

    // ---- directed ----
    // empty table: check misses, delete finds nothing
    push_request(REQ_CHECK, KIND_CPU_WRITE, 32'h0, 8'd0, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0);
    push_request(REQ_DELETE, 3'd0, 32'h0000_1001, 8'd0, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0);
    // palette entry, span 1 at an odd address: only the low byte of the
    // expanded color (0x1FF -> 0xEEE) is compared
    push_request(REQ_ADD, 3'd0, 32'h0000_1001, 8'd1, 32'h0, 8'h02, 1'b1, 32'h0000_00EE, 1'b0);
    push_request(REQ_CHECK, KIND_PALETTE_WRITE, 32'h0000_1001, 8'd0, 32'hFFFF_FFFF,
                 8'h00, 1'b0, 32'h0, 1'b0);
    // once-only processor-write entry; the check carries junk in the top
    // byte, hits after masking, and the entry goes away
    push_request(REQ_ADD, 3'd0, 32'h0012_3456, 8'hFF, 32'h0, 8'h01, 1'b0, 32'h0, 1'b1);
    push_request(REQ_CHECK, KIND_CPU_WRITE, 32'hFF12_3500, 8'd0, $urandom,
                 8'h00, 1'b0, 32'h0, 1'b0);
    // all-ones entry and access: range sums must not wrap
    push_request(REQ_ADD, 3'd0, 32'hFFFF_FFFF, 8'hFF, 32'h0, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
    push_request(REQ_CHECK, 3'd7, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                 8'h00, 1'b0, 32'h0, 1'b0);
    // same access, value condition fails
    push_request(REQ_CHECK, 3'd7, 32'hFFFF_FFFF, 8'hFF, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0);
    // fill the table; the last add is refused
    for (k = 0; k < 15; k++)
      push_request(REQ_ADD, 3'($urandom), 32'h0000_2000 + k, 8'd0, $urandom,
                   8'h01, 1'b0, $urandom, 1'b0);
    // access end touching an entry start still hits (slot 2)
    push_request(REQ_CHECK, KIND_CPU_WRITE, 32'h0000_1FFF, 8'd1, 32'h0,
                 8'h00, 1'b0, 32'h0, 1'b0);
    // delete the head entry: everything shifts down
    push_request(REQ_DELETE, 3'd0, 32'h0000_1001, 8'd0, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0);
    push_request(REQ_CLEAR, 3'd0, 32'h0, 8'd0, 32'h0, 8'h00, 1'b0, 32'h0, 1'b0);

    // ---- random ----
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      quiet = (blk >= RANDOM_BLOCKS - 2) || ($urandom_range(0, 4) == 0);
      heavy = $urandom_range(0, 1);
      repeat (BLOCK_ITEMS) random_request(heavy);
    end
    @(negedge clk);
    in_valid = 1'b0;

    // every result transaction back, then the drain cycles for strays
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results == 0)
      $display("** watchpoint_table_matcher: PASSED **");
    else
      $display("** watchpoint_table_matcher: FAILED **");
    $finish;
  end

endmodule

[watchpoint_table_matcher.f]
rtl/wtm_pkg.sv
rtl/wtm_cell.sv
rtl/watchpoint_table_matcher.sv
tb/watchpoint_table_matcher_checker.sv
tb/tb_watchpoint_table_matcher.sv
